### design/duty_gated_waveform_sample_defines.svh
// assertion macros for the duty gated waveform sample block
// expects signals named clock and reset in the including module
`ifndef DUTY_GATED_WAVEFORM_SAMPLE_DEFINES_SVH
`define DUTY_GATED_WAVEFORM_SAMPLE_DEFINES_SVH

// same-cycle implication, off while reset is high
`define DGWS_ASSERT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dgws check failed");

// next-cycle implication, off while reset is high
`define DGWS_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dgws check failed");

`endif

### design/dgws_pkg.sv
// shared constants, types and the quarter-wave sine table for the waveform sample block
// no dependencies
`timescale 1ns / 1ps

package dgws_pkg;

   localparam int PHASE_FRAC_BITS  = 16;
   localparam int SINE_TABLE_DEPTH = 256;

   localparam int COUNT_BITS     = 17;
   localparam int DUTY_BITS      = 7;
   localparam int KIND_BITS      = 3;
   localparam int CODE_BITS      = 12;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 17;
   localparam int REQ_DATA_BITS  = 24;
   localparam int RSP_DATA_BITS  = 16;

   // count*100 and period*duty both fit here
   localparam int WINDOW_BITS = COUNT_BITS + DUTY_BITS;

   localparam int QUAD_REM_BITS   = PHASE_FRAC_BITS - 2;
   localparam int SINE_ENTRY_BITS = 11;
   localparam int SINE_IDX_BITS   = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int SINE_ADDR_BITS  = $clog2(SINE_TABLE_DEPTH);

   localparam logic [CODE_BITS-1:0]     CODE_MAX     = 12'd4095;
   localparam logic [CODE_BITS-1:0]     SINE_MID     = 12'd2047;
   localparam logic [COUNT_BITS-1:0]    PERIOD_RESET = 17'd1000;
   localparam logic [DUTY_BITS-1:0]     DUTY_RESET   = 7'd50;
   localparam logic [63:0]              HALF_PI_Q30  = 64'd1686629713;

   typedef enum logic [KIND_BITS-1:0] {
      WAVE_SQUARE,
      WAVE_SINE,
      WAVE_TRIANGLE,
      WAVE_FLAT_TOP,
      WAVE_SAWTOOTH
   } wave_kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PERIOD,
      CSR_DUTY,
      CSR_KIND
   } csr_index_type;

   typedef enum logic [1:0] {
      FLAT_RISE,
      FLAT_HOLD,
      FLAT_FALL
   } flat_seg_type;

   // travels with every word down the pipe
   typedef struct packed {
      logic valid;
      logic win;
      logic sat;
   } item_tag_type;

   // entry k holds the quarter-wave value for index k+1, index 0 is zero
   typedef logic [SINE_TABLE_DEPTH-1:0][SINE_ENTRY_BITS-1:0] sine_rom_type;

   // elaboration only: q30 taylor series up to x^11, rounded and capped
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  v;
      longint       sum;
      int           i;
      rom = '0;
      for (i = 1; i <= SINE_TABLE_DEPTH; i++) begin
         x    = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
         x2   = (x * x) >> 30;
         sum  = longint'(x);
         term = ((x * x2) >> 30) / 6;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / 20;
         sum  = sum + longint'(term);
         term = ((term * x2) >> 30) / 42;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / 72;
         sum  = sum + longint'(term);
         term = ((term * x2) >> 30) / 110;
         sum  = sum - longint'(term);
         if (sum < 0) begin
            sum = 0;
         end
         v = (64'(sum) * 64'd2047 + (64'd1 << 29)) >> 30;
         if (v > 64'd2047) begin
            v = 64'd2047;
         end
         rom[i-1] = v[SINE_ENTRY_BITS-1:0];
      end
      return rom;
   endfunction

endpackage

### design/dgws_div_pipe.sv
// restoring divider, one quotient bit per register stage: phase = (count << F) / period
// depends on dgws_pkg
`timescale 1ns / 1ps

module dgws_div_pipe (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  dgws_pkg::item_tag_type                in_tag,
   input  logic [dgws_pkg::COUNT_BITS-1:0]       in_rem,
   input  logic [dgws_pkg::COUNT_BITS-1:0]       divisor,
   output dgws_pkg::item_tag_type                out_tag,
   output logic [dgws_pkg::PHASE_FRAC_BITS-1:0]  out_quo
);

   localparam int F  = dgws_pkg::PHASE_FRAC_BITS;
   localparam int RB = dgws_pkg::COUNT_BITS;

   dgws_pkg::item_tag_type tag_ff [F];
   logic [RB-1:0]          rem_ff [F];
   logic [F-1:0]           quo_ff [F];
   logic [RB-1:0]          rem_in [F];
   logic [F-1:0]           quo_in [F];

   for (genvar k = 0; k < F; k++) begin : g_stage
      dgws_pkg::item_tag_type tag_prev;
      logic [RB-1:0]          rem_prev;
      logic [F-1:0]           quo_prev;
      logic [RB:0]            shifted;
      logic [RB:0]            diff;
      logic                   take;

      if (k == 0) begin : g_first
         assign tag_prev = in_tag;
         assign rem_prev = in_rem;
         assign quo_prev = '0;
      end else begin : g_next
         assign tag_prev = tag_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      assign shifted   = {rem_prev, 1'b0};
      assign take      = (shifted >= {1'b0, divisor});
      assign diff      = shifted - {1'b0, divisor};
      assign rem_in[k] = take ? diff[RB-1:0] : shifted[RB-1:0];
      assign quo_in[k] = {quo_prev[F-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k] <= '0;
         end else if (adv) begin
            tag_ff[k] <= tag_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign out_tag = tag_ff[F-1];
   assign out_quo = quo_ff[F-1];

endmodule

### design/dgws_shape.sv
// wave shaping: constant products and sine index, then table read, select and output register
// depends on dgws_pkg
`timescale 1ns / 1ps

module dgws_shape (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  dgws_pkg::item_tag_type                in_tag,
   input  logic [dgws_pkg::PHASE_FRAC_BITS-1:0]  in_quo,
   input  logic [dgws_pkg::KIND_BITS-1:0]        wave_kind,
   output logic                                  out_valid,
   output logic [dgws_pkg::CODE_BITS-1:0]        out_code,
   output logic                                  out_win
);

   localparam int F   = dgws_pkg::PHASE_FRAC_BITS;
   localparam int CB  = dgws_pkg::CODE_BITS;
   localparam int QB  = dgws_pkg::QUAD_REM_BITS;
   localparam int IB  = dgws_pkg::SINE_IDX_BITS;
   localparam int AB  = dgws_pkg::SINE_ADDR_BITS;
   localparam dgws_pkg::sine_rom_type SineRom = dgws_pkg::build_sine_rom();

   // first stage: products by constants
   logic [F-1:0]      phase;
   logic [F+11:0]     saw_prod;
   logic [F-1:0]      tri_arg;
   logic [F+13:0]     tri_prod;
   logic [F+2:0]      p5;
   logic [F+11:0]     flat_prod;
   logic [QB+IB-1:0]  j_prod;
   logic [AB-1:0]     sine_j;

   logic [CB-1:0]          saw_in, tri_in, flat_in;
   dgws_pkg::flat_seg_type flat_seg_in;
   logic [IB-1:0]          sine_idx_in;

   dgws_pkg::item_tag_type tag_ff;
   logic [CB-1:0]          saw_ff, tri_ff, flat_ff;
   dgws_pkg::flat_seg_type flat_seg_ff;
   logic [IB-1:0]          sine_idx_ff;
   logic                   sine_neg_ff;

   always_comb begin
      // count at or past the period pins the phase at q-1
      phase    = in_tag.sat ? '1 : in_quo;
      saw_prod = {phase, 12'b0} - (F+12)'(phase);
      saw_in   = saw_prod[F+11:F];

      tri_arg  = phase[F-1] ? F'(~phase + F'(1)) : phase;
      tri_prod = {tri_arg, 14'b0} - {tri_arg, 2'b0};
      tri_prod = tri_prod >> 1;
      tri_in   = (tri_prod[F+13:F] > (F+14-F)'(dgws_pkg::CODE_MAX))
                 ? dgws_pkg::CODE_MAX : tri_prod[F+11:F];

      // below q and above 4q the operand is the low F bits of 5p
      p5        = {phase, 2'b0} + (F+3)'(phase);
      flat_prod = {p5[F-1:0], 12'b0} - (F+12)'(p5[F-1:0]);
      flat_in   = flat_prod[F+11:F];
      if (p5[F+2:F] == 3'd0) begin
         flat_seg_in = dgws_pkg::FLAT_RISE;
      end else if (p5 <= {3'b100, {F{1'b0}}}) begin
         flat_seg_in = dgws_pkg::FLAT_HOLD;
      end else begin
         flat_seg_in = dgws_pkg::FLAT_FALL;
      end

      j_prod = (QB+IB)'(phase[QB-1:0]) * (QB+IB)'(dgws_pkg::SINE_TABLE_DEPTH);
      sine_j = j_prod[QB+AB-1:QB];
      sine_idx_in = phase[F-2] ? IB'(IB'(dgws_pkg::SINE_TABLE_DEPTH) - IB'(sine_j))
                               : IB'(sine_j);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (adv) begin
         tag_ff <= in_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         saw_ff      <= saw_in;
         tri_ff      <= tri_in;
         flat_ff     <= flat_in;
         flat_seg_ff <= flat_seg_in;
         sine_idx_ff <= sine_idx_in;
         sine_neg_ff <= phase[F-1];
      end
   end

   // second stage: table read and selection
   logic [IB-1:0]               idx_m1;
   logic [dgws_pkg::SINE_ENTRY_BITS-1:0] sine_entry;
   logic [CB-1:0]               sine_code;
   logic [CB-1:0]               flat_code;
   logic [CB-1:0]               shape_code;
   logic [CB-1:0]               code_in;

   logic          valid_ff;
   logic [CB-1:0] code_ff;
   logic          win_ff;

   always_comb begin
      idx_m1     = sine_idx_ff - IB'(1);
      sine_entry = (sine_idx_ff == '0) ? '0 : SineRom[idx_m1[AB-1:0]];
      sine_code  = sine_neg_ff ? (dgws_pkg::SINE_MID - CB'(sine_entry))
                               : (dgws_pkg::SINE_MID + CB'(sine_entry));
      case (flat_seg_ff)
         dgws_pkg::FLAT_RISE: flat_code = flat_ff;
         dgws_pkg::FLAT_HOLD: flat_code = dgws_pkg::CODE_MAX;
         dgws_pkg::FLAT_FALL: flat_code = dgws_pkg::CODE_MAX - flat_ff;
         default:             flat_code = '0;
      endcase
      case (dgws_pkg::wave_kind_type'(wave_kind))
         dgws_pkg::WAVE_SQUARE:   shape_code = dgws_pkg::CODE_MAX;
         dgws_pkg::WAVE_SINE:     shape_code = sine_code;
         dgws_pkg::WAVE_TRIANGLE: shape_code = tri_ff;
         dgws_pkg::WAVE_FLAT_TOP: shape_code = flat_code;
         dgws_pkg::WAVE_SAWTOOTH: shape_code = saw_ff;
         default:                 shape_code = '0;
      endcase
      code_in = tag_ff.win ? shape_code : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= tag_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         code_ff <= code_in;
         win_ff  <= tag_ff.win;
      end
   end

   assign out_valid = valid_ff;
   assign out_code  = code_ff;
   assign out_win   = win_ff;

endmodule

### design/duty_gated_waveform_sample.sv
// an accepted req word passes the window, divider and shape stage registers to rsp_tvalid
// throughput: one word per cycle unless held; restoring divider, one phase bit per stage
// the whole pipe advances when the output register is empty or taken, else it holds
// reset (synchronous, active high) empties the pipe and loads period 1000, duty 50, square
// depends on dgws_pkg, dgws_div_pipe, dgws_shape and the defines header
`timescale 1ns / 1ps
`include "duty_gated_waveform_sample_defines.svh"

module duty_gated_waveform_sample (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [dgws_pkg::REQ_DATA_BITS-1:0]     req_tdata,  // phase_count[16:0], zero pad
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [dgws_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,  // dac_code[11:0], zero pad
   output logic                                   rsp_tuser,  // in_window[0]
   input  logic                                   csr_we,
   input  logic [dgws_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [dgws_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int CNT = dgws_pkg::COUNT_BITS;
   localparam int WB  = dgws_pkg::WINDOW_BITS;

   // configuration registers
   logic [CNT-1:0]                  period_ticks_ff, period_ticks_in;
   logic [dgws_pkg::DUTY_BITS-1:0]  duty_percent_ff, duty_percent_in;
   logic [dgws_pkg::KIND_BITS-1:0]  wave_kind_ff, wave_kind_in;

   always_comb begin
      period_ticks_in = period_ticks_ff;
      duty_percent_in = duty_percent_ff;
      wave_kind_in    = wave_kind_ff;
      if (csr_we) begin
         case (dgws_pkg::csr_index_type'(csr_index))
            dgws_pkg::CSR_PERIOD: period_ticks_in = csr_wdata;
            dgws_pkg::CSR_DUTY:   duty_percent_in = csr_wdata[dgws_pkg::DUTY_BITS-1:0];
            dgws_pkg::CSR_KIND:   wave_kind_in    = csr_wdata[dgws_pkg::KIND_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ticks_ff <= dgws_pkg::PERIOD_RESET;
         duty_percent_ff <= dgws_pkg::DUTY_RESET;
         wave_kind_ff    <= dgws_pkg::WAVE_SQUARE;
      end else begin
         period_ticks_ff <= period_ticks_in;
         duty_percent_ff <= duty_percent_in;
         wave_kind_ff    <= wave_kind_in;
      end
   end

   // handshake: the whole pipe moves together
   logic adv;
   logic accept;
   logic out_valid;
   logic [dgws_pkg::CODE_BITS-1:0] out_code;
   logic out_win;

   assign adv        = !out_valid || rsp_tready;
   assign req_tready = adv && !reset;
   assign accept     = req_tvalid && req_tready;

   // window stage: count <= floor(per*duty/100) is the same as 100*count <= per*duty
   logic [CNT-1:0]          count;
   logic [CNT-1:0]          period_eff;
   logic [WB-1:0]           count_x100;
   logic [WB-1:0]           window_limit;
   dgws_pkg::item_tag_type  s1_tag_in, s1_tag_ff;
   logic [CNT-1:0]          s1_count_ff;

   always_comb begin
      count        = req_tdata[CNT-1:0];
      period_eff   = (period_ticks_ff == '0) ? CNT'(1) : period_ticks_ff;
      count_x100   = (WB'(count) << 6) + (WB'(count) << 5) + (WB'(count) << 2);
      window_limit = WB'(period_eff) * WB'(duty_percent_ff);
      s1_tag_in.valid = accept;
      s1_tag_in.win   = (count_x100 <= window_limit);
      s1_tag_in.sat   = (count >= period_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
      end else if (adv) begin
         s1_tag_ff <= s1_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_count_ff <= count;
      end
   end

   dgws_pkg::item_tag_type                div_tag;
   logic [dgws_pkg::PHASE_FRAC_BITS-1:0]  div_quo;

   dgws_div_pipe u_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_tag  (s1_tag_ff),
      .in_rem  (s1_count_ff),
      .divisor (period_eff),
      .out_tag (div_tag),
      .out_quo (div_quo)
   );

   dgws_shape u_shape (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_tag    (div_tag),
      .in_quo    (div_quo),
      .wave_kind (wave_kind_ff),
      .out_valid (out_valid),
      .out_code  (out_code),
      .out_win   (out_win)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {{(dgws_pkg::RSP_DATA_BITS - dgws_pkg::CODE_BITS){1'b0}}, out_code};
   assign rsp_tuser  = out_win;

   // an empty output register never holds back the input side
   `DGWS_ASSERT(a_idle_ready, !rsp_tvalid, req_tready)
   // a held output word blocks every stage behind it
   `DGWS_ASSERT(a_stall_blocks, rsp_tvalid && !rsp_tready, !req_tready)
   // outside the duty window the code is forced low
   `DGWS_ASSERT(a_gate_zero, rsp_tvalid && !rsp_tuser, rsp_tdata[11:0] == 12'd0)
   `DGWS_ASSERT(a_square_full,
      rsp_tvalid && rsp_tuser && (wave_kind_ff == dgws_pkg::WAVE_SQUARE),
      rsp_tdata[11:0] == dgws_pkg::CODE_MAX)
   // an accepted word lands in the window stage
   `DGWS_ASSERT_NEXT(a_window_capture, req_tvalid && req_tready, s1_tag_ff.valid)

endmodule

### bench/duty_gated_waveform_sample_test.sv
// self-checking bench for duty_gated_waveform_sample: directed shape and corner words, then random traffic
// predicts each dac code from a local copy of the registers and its own quarter-wave sine table
// depends on dgws_pkg and the duty_gated_waveform_sample rtl
`timescale 1ns / 1ps

module duty_gated_waveform_sample_test;

   localparam int COUNT_BITS       = dgws_pkg::COUNT_BITS;
   localparam int PHASE_FRAC_BITS  = dgws_pkg::PHASE_FRAC_BITS;
   localparam int CSR_INDEX_BITS   = dgws_pkg::CSR_INDEX_BITS;
   localparam int CSR_DATA_BITS    = dgws_pkg::CSR_DATA_BITS;
   localparam int KIND_BITS        = dgws_pkg::KIND_BITS;
   localparam int DUTY_BITS        = dgws_pkg::DUTY_BITS;
   localparam int CODE_BITS        = dgws_pkg::CODE_BITS;
   localparam int REQ_DATA_BITS    = dgws_pkg::REQ_DATA_BITS;
   localparam int RSP_DATA_BITS    = dgws_pkg::RSP_DATA_BITS;
   localparam int SINE_TABLE_DEPTH = dgws_pkg::SINE_TABLE_DEPTH;
   localparam int QUAD_REM_BITS    = dgws_pkg::QUAD_REM_BITS;
   localparam logic [CODE_BITS-1:0] CODE_MAX = dgws_pkg::CODE_MAX;
   localparam logic [CODE_BITS-1:0] SINE_MID = dgws_pkg::SINE_MID;
   localparam logic [63:0]          HALF_PI_Q30 = dgws_pkg::HALF_PI_Q30;

   localparam longint       COUNT_MAX    = (64'd1 << COUNT_BITS) - 1;
   localparam logic [63:0]  PHASE_ONE    = 64'd1 << PHASE_FRAC_BITS;
   localparam int           HOLD_CYCLES  = 300;
   localparam int           LIMIT_CYCLES = 500000;
   localparam int           SETTLE       = PHASE_FRAC_BITS + 6;
   localparam int           RAND_PHASES  = 12;
   localparam int           PHASE_WORDS  = 100;
   // index past the register list, writes there must be dropped
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED       = 2'd3;
   localparam logic [KIND_BITS-1:0]      KIND_SPARE_FIRST = 3'd5;
   localparam logic [KIND_BITS-1:0]      KIND_SPARE_LAST  = 3'd7;

   typedef enum logic [1:0] {
      READY_FULL,
      READY_PATTERN,
      READY_RANDOM
   } ready_mode_type;

   typedef struct packed {
      logic [CODE_BITS-1:0] code;
      logic                 win;
   } dac_sample_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      rsp_tuser;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // shadow of the block's registers
   logic [COUNT_BITS-1:0] cfg_period = dgws_pkg::PERIOD_RESET;
   logic [DUTY_BITS-1:0]  cfg_duty   = dgws_pkg::DUTY_RESET;
   logic [KIND_BITS-1:0]  cfg_kind   = dgws_pkg::WAVE_SQUARE;

   logic [CODE_BITS-1:0] sine_quarter [0:SINE_TABLE_DEPTH];
   dac_sample_type       pending_samples [$];
   int                   errors = 0;
   int                   cycle_count = 0;

   ready_mode_type ready_mode = READY_FULL;
   // toggled by the test to ask for a long hold
   logic           hold_req = 1'b0;
   logic           hold_seen = 1'b0;
   int             hold_left = 0;
   logic [12:0]    stall_rot = 13'b1101101011101;

   duty_gated_waveform_sample u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // q30 taylor series of sin up to x^11, rounded to 2047 full scale
   function automatic void fill_sine_quarter();
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] v;
      longint      acc;
      int          i;
      int          k;
      for (i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x    = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
         x2   = (x * x) >> 30;
         term = x;
         acc  = longint'(x);
         for (k = 1; k <= 5; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         v = (64'(acc) * 64'd2047 + (64'd1 << 29)) >> 30;
         if (v > 64'(SINE_MID)) begin
            v = 64'(SINE_MID);
         end
         sine_quarter[i] = v[CODE_BITS-1:0];
      end
   endfunction

   function automatic logic [63:0] sine_code(logic [63:0] ph);
      logic [1:0]  quad;
      logic [63:0] idx;
      logic [63:0] mag;
      quad = ph[PHASE_FRAC_BITS-1 -: 2];
      idx  = ((ph & ((64'd1 << QUAD_REM_BITS) - 1)) * SINE_TABLE_DEPTH) >> QUAD_REM_BITS;
      // odd quadrants run the table backwards
      mag  = quad[0] ? 64'(sine_quarter[SINE_TABLE_DEPTH - idx]) : 64'(sine_quarter[idx]);
      return quad[1] ? 64'(SINE_MID) - mag : 64'(SINE_MID) + mag;
   endfunction

   function automatic dac_sample_type waveform_sample(logic [COUNT_BITS-1:0] count);
      logic [63:0]    per;
      logic [63:0]    thr;
      logic [63:0]    ph;
      logic [63:0]    v;
      logic [63:0]    d;
      dac_sample_type s;
      per    = (cfg_period == 0) ? 64'd1 : 64'(cfg_period);
      thr    = (per * cfg_duty) / 100;
      s.code = '0;
      s.win  = 1'b0;
      if (64'(count) > thr) begin
         return s;
      end
      ph = (64'(count) << PHASE_FRAC_BITS) / per;
      if (ph >= PHASE_ONE) begin
         ph = PHASE_ONE - 1;
      end
      case (cfg_kind)
         dgws_pkg::WAVE_SQUARE:   v = 64'(CODE_MAX);
         dgws_pkg::WAVE_SINE:     v = sine_code(ph);
         dgws_pkg::WAVE_TRIANGLE: begin
            v = ((ph < PHASE_ONE / 2) ? ph : PHASE_ONE - ph) * 8190 >> PHASE_FRAC_BITS;
         end
         dgws_pkg::WAVE_FLAT_TOP: begin
            if (ph * 5 < PHASE_ONE) begin
               v = (ph * 5 * CODE_MAX) >> PHASE_FRAC_BITS;
            end else if (ph * 5 <= 4 * PHASE_ONE) begin
               v = 64'(CODE_MAX);
            end else begin
               d = ((ph * 5 - 4 * PHASE_ONE) * CODE_MAX) >> PHASE_FRAC_BITS;
               v = (d >= 64'(CODE_MAX)) ? 64'd0 : 64'(CODE_MAX) - d;
            end
         end
         dgws_pkg::WAVE_SAWTOOTH: v = (ph * CODE_MAX) >> PHASE_FRAC_BITS;
         default:                 v = 64'd0;
      endcase
      if (v > 64'(CODE_MAX)) begin
         v = 64'(CODE_MAX);
      end
      s.code = v[CODE_BITS-1:0];
      s.win  = 1'b1;
      return s;
   endfunction

   // mostly inside the window, some around the threshold and the period
   function automatic logic [COUNT_BITS-1:0] pick_count();
      longint      per;
      longint      thr;
      longint      c;
      int unsigned sel;
      per = (cfg_period == 0) ? longint'(1) : longint'(cfg_period);
      thr = (per * cfg_duty) / 100;
      sel = $urandom_range(99);
      if (sel < 60) begin
         c = longint'($urandom_range(0, int'((thr > COUNT_MAX) ? COUNT_MAX : thr)));
      end else if (sel < 75) begin
         c = thr + longint'($urandom_range(0, 6)) - 3;
      end else if (sel < 85) begin
         c = per + longint'($urandom_range(0, 4)) - 2;
      end else begin
         c = longint'($urandom_range(0, int'(COUNT_MAX)));
      end
      if (c < 0) begin
         c = 0;
      end
      if (c > COUNT_MAX) begin
         c = COUNT_MAX;
      end
      return c[COUNT_BITS-1:0];
   endfunction

   task automatic send_count(input logic [COUNT_BITS-1:0] count);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_BITS'(count);
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      pending_samples.push_back(waveform_sample(count));
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // stop sending and wait for every outstanding word
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_samples.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         dgws_pkg::CSR_PERIOD: cfg_period = value[COUNT_BITS-1:0];
         dgws_pkg::CSR_DUTY:   cfg_duty   = value[DUTY_BITS-1:0];
         dgws_pkg::CSR_KIND:   cfg_kind   = value[KIND_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [COUNT_BITS-1:0] period,
                            input logic [DUTY_BITS-1:0]  duty,
                            input logic [KIND_BITS-1:0]  kind);
      csr_write(dgws_pkg::CSR_PERIOD, CSR_DATA_BITS'(period));
      csr_write(dgws_pkg::CSR_DUTY, CSR_DATA_BITS'(duty));
      csr_write(dgws_pkg::CSR_KIND, CSR_DATA_BITS'(kind));
      csr_we <= 1'b0;
   endtask

   // reset values: period 1000, duty 50, square
   task automatic test_reset_defaults();
      ready_mode <= READY_FULL;
      send_count('0);
      send_count(17'd500);
      send_count(17'd501);
      send_count('1);
      drain();
   endtask

   // period 65536 makes the phase equal the count, so segment edges land exactly
   task automatic test_wave_shapes();
      ready_mode <= READY_PATTERN;
      configure(17'd65536, 7'd100, dgws_pkg::WAVE_SINE);
      send_count(17'd16383);
      send_count(17'd16384);
      send_count(17'd49151);
      drain();
      configure(17'd65536, 7'd100, dgws_pkg::WAVE_TRIANGLE);
      send_count(17'd32767);
      send_count(17'd32768);
      drain();
      configure(17'd65536, 7'd100, dgws_pkg::WAVE_FLAT_TOP);
      send_count(17'd13107);
      send_count(17'd13108);
      send_count(17'd52429);
      drain();
      configure(17'd65536, 7'd100, dgws_pkg::WAVE_SAWTOOTH);
      send_count(17'd65535);
      send_count(17'd65536);
      drain();
      // window past one period, phase pinned at its top
      configure(17'd65536, 7'd127, dgws_pkg::WAVE_SAWTOOTH);
      send_count(17'd83230);
      send_count(17'd83231);
      drain();
   endtask

   task automatic test_special_cases();
      ready_mode <= READY_RANDOM;
      // zero period acts as one
      configure('0, 7'd100, dgws_pkg::WAVE_SAWTOOTH);
      send_count(17'd0);
      send_count(17'd1);
      send_count(17'd2);
      drain();
      // zero duty leaves only count zero in the window
      configure(17'd1000, 7'd0, dgws_pkg::WAVE_TRIANGLE);
      send_count(17'd0);
      send_count(17'd1);
      drain();
      configure(17'd1000, 7'd100, KIND_SPARE_FIRST);
      send_count(17'd10);
      drain();
      configure(17'd1000, 7'd50, KIND_SPARE_LAST);
      send_count(17'd900);
      drain();
      // write past the register list is dropped
      csr_write(CSR_UNUSED, '1);
      csr_we <= 1'b0;
      send_count(17'd10);
      drain();
      // upper write bits are masked off
      csr_write(dgws_pkg::CSR_KIND, 17'h1FFF8 | CSR_DATA_BITS'(dgws_pkg::WAVE_SQUARE));
      csr_we <= 1'b0;
      send_count(17'd10);
      drain();
   endtask

   // receiver holds off while words keep coming, so the pipe backs up to the input
   task automatic test_backpressure();
      int i;
      configure(17'd100000, 7'd100, dgws_pkg::WAVE_SINE);
      ready_mode <= READY_FULL;
      hold_req   <= ~hold_req;
      for (i = 0; i < 80; i++) begin
         send_count(pick_count());
      end
      drain();
   endtask

   task automatic pick_config();
      logic [COUNT_BITS-1:0] period;
      logic [DUTY_BITS-1:0]  duty;
      logic [KIND_BITS-1:0]  kind;
      int unsigned           sel;
      sel = $urandom_range(99);
      if (sel < 8) begin
         period = COUNT_BITS'($urandom_range(0, 99));
      end else if (sel < 16) begin
         period = COUNT_BITS'($urandom());
      end else if (sel < 24) begin
         period = 17'd65536;
      end else if (sel < 28) begin
         period = '1;
      end else begin
         period = COUNT_BITS'($urandom_range(100, 100000));
      end
      sel = $urandom_range(99);
      if (sel < 10) begin
         duty = DUTY_BITS'($urandom_range(101, 127));
      end else if (sel < 15) begin
         duty = '0;
      end else if (sel < 22) begin
         duty = 7'd100;
      end else begin
         duty = DUTY_BITS'($urandom_range(1, 99));
      end
      kind = ($urandom_range(99) < 88) ? KIND_BITS'($urandom_range(0, 4))
                                       : KIND_BITS'($urandom_range(5, 7));
      csr_write(dgws_pkg::CSR_PERIOD, period);
      csr_write(dgws_pkg::CSR_DUTY, {10'($urandom()), duty});
      csr_write(dgws_pkg::CSR_KIND, {14'($urandom()), kind});
      csr_we <= 1'b0;
   endtask

   task automatic test_random_traffic();
      int   phase;
      int   sent;
      int   burst;
      int   i;
      logic no_gaps;
      for (phase = 0; phase < RAND_PHASES; phase++) begin
         pick_config();
         ready_mode <= (phase == 0) ? READY_FULL : ready_mode_type'($urandom_range(0, 2));
         no_gaps = (phase % 4 == 0);
         sent    = 0;
         while (sent < PHASE_WORDS) begin
            burst = $urandom_range(1, 24);
            for (i = 0; i < burst && sent < PHASE_WORDS; i++) begin
               send_count(pick_count());
               sent++;
            end
            if (!no_gaps && $urandom_range(9) < 7) begin
               pause_sender($urandom_range(1, 8));
            end
         end
         drain();
      end
   endtask

   // receiver: long hold on request, else full, rotating pattern or random
   always @(posedge clock) begin
      stall_rot <= {stall_rot[11:0], stall_rot[12]};
      hold_seen <= hold_req;
      if (hold_req != hold_seen) begin
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (ready_mode)
            READY_FULL:    rsp_tready <= 1'b1;
            READY_PATTERN: rsp_tready <= stall_rot[0];
            default:       rsp_tready <= ($urandom_range(3) != 0);
         endcase
      end
   end

   always @(posedge clock) begin : check_samples
      dac_sample_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_samples.size() == 0) begin
            $error("unexpected word: dac_code %0d in_window %0d",
                   rsp_tdata[CODE_BITS-1:0], rsp_tuser);
            errors++;
         end else begin
            want = pending_samples.pop_front();
            if (rsp_tdata[CODE_BITS-1:0] !== want.code) begin
               $error("dac_code expected %0d actual %0d", want.code, rsp_tdata[CODE_BITS-1:0]);
               errors++;
            end
            if (rsp_tuser !== want.win) begin
               $error("in_window expected %0d actual %0d", want.win, rsp_tuser);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      fill_sine_quarter();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_wave_shapes();
      test_special_cases();
      test_backpressure();
      test_random_traffic();
      drain();
      repeat (SETTLE) @(posedge clock);
      if (errors == 0 && pending_samples.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### files.f
+incdir+design
design/dgws_pkg.sv
design/dgws_div_pipe.sv
design/dgws_shape.sv
design/duty_gated_waveform_sample.sv
bench/duty_gated_waveform_sample_test.sv
